// ===== design/slrp_pkg.sv =====
// Shared constants, codes and control types of the scrollback line ring pager.
package slrp_pkg;

  localparam int POOL_BYTES_DEF = 4096;
  localparam int MAX_LINES_DEF  = 256;
  localparam int MAX_COLS_DEF   = 40;

  localparam logic [7:0] PAD_ATTR = 8'h02;
  localparam logic [7:0] BLANK    = 8'h20;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 56;
  localparam int CIDX_W = 2;
  localparam int CFG_W  = 6;

  localparam logic [CIDX_W-1:0] REG_FIRST_ROW = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ROWS      = 2'd1;
  localparam logic [CIDX_W-1:0] REG_COLS      = 2'd2;

  typedef enum logic [2:0] {
    ACT_PUT, ACT_EOL, ACT_PGUP, ACT_PGDN, ACT_HOME, ACT_END, ACT_PAINT, ACT_CLEAR
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_STAT, S_WRAP, S_EVRD, S_EVCHK, S_FULL, S_CPRD, S_CPWR,
    S_DESC, S_VIEW, S_PCHK, S_PDESC, S_PRD, S_PLD
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic stat_load;
    logic wrap;
    logic ev_rd;
    logic ev_drop;
    logic full;
    logic cp_rd;
    logic cp_wr;
    logic desc_wr;
    logic view_upd;
    logic p_start;
    logic p_desc;
    logic p_rd;
    logic p_ld;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    row_ok;
    logic    have_lines;
    logic    ev_hit;
    logic    cp_more;
    logic    last_col;
    logic    out_free;
  } stat_t;

endpackage

// ===== design/slrp_ctrl.sv =====
// Controller state machine sequencing commit, eviction, copy and paint steps.
module slrp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  slrp_pkg::stat_t stat,
  output slrp_pkg::cmd_t  cmd
);
  import slrp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_EXEC;
      S_EXEC: begin
        unique case (stat.action)
          ACT_EOL:   state_next = S_WRAP;
          ACT_PAINT: state_next = S_PCHK;
          default:   state_next = S_STAT;
        endcase
      end
      S_STAT:  if (stat.out_free) state_next = S_IDLE;
      S_WRAP:  state_next = S_EVRD;
      S_EVRD:  state_next = stat.have_lines ? S_EVCHK : S_FULL;
      S_EVCHK: state_next = stat.ev_hit ? S_EVRD : S_FULL;
      S_FULL:  state_next = S_CPRD;
      S_CPRD:  state_next = stat.cp_more ? S_CPWR : S_DESC;
      S_CPWR:  state_next = S_CPRD;
      S_DESC:  state_next = S_VIEW;
      S_VIEW:  state_next = S_STAT;
      S_PCHK:  state_next = stat.row_ok ? S_PDESC : S_STAT;
      S_PDESC: state_next = S_PRD;
      S_PRD:   if (stat.out_free) state_next = S_PLD;
      S_PLD:   state_next = stat.last_col ? S_IDLE : S_PRD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      S_EXEC:  cmd.exec = (stat.action != ACT_EOL) && (stat.action != ACT_PAINT);
      S_STAT:  cmd.stat_load = stat.out_free;
      S_WRAP:  cmd.wrap = 1'b1;
      S_EVRD:  cmd.ev_rd = stat.have_lines;
      S_EVCHK: cmd.ev_drop = stat.ev_hit;
      S_FULL:  cmd.full = 1'b1;
      S_CPRD:  cmd.cp_rd = stat.cp_more;
      S_CPWR:  cmd.cp_wr = 1'b1;
      S_DESC:  cmd.desc_wr = 1'b1;
      S_VIEW:  cmd.view_upd = 1'b1;
      S_PCHK:  cmd.p_start = stat.row_ok;
      S_PDESC: cmd.p_desc = 1'b1;
      S_PRD:   cmd.p_rd = stat.out_free;
      S_PLD:   cmd.p_ld = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/slrp_datapath.sv =====
// Datapath: configuration, stage, byte pools, line descriptors, view and output register.
module slrp_datapath #(
  parameter int POOL_BYTES = slrp_pkg::POOL_BYTES_DEF,
  parameter int MAX_LINES  = slrp_pkg::MAX_LINES_DEF,
  parameter int MAX_COLS   = slrp_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  slrp_pkg::cmd_t              cmd,
  output slrp_pkg::stat_t             stat,
  input  logic                        cfg_we,
  input  logic [slrp_pkg::CIDX_W-1:0] cfg_index,
  input  logic [slrp_pkg::CFG_W-1:0]  cfg_data,
  input  logic [slrp_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [slrp_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tlast
);
  import slrp_pkg::*;

  localparam int PW = $clog2(POOL_BYTES);
  localparam int HW = $clog2(POOL_BYTES + 1);
  localparam int AW = HW + 1;
  localparam int LW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int SW = $clog2(MAX_COLS);
  localparam int EW = $clog2(MAX_COLS + 1);
  localparam int NW = CW + 6;
  localparam int DW = HW + EW;

  logic [4:0]     first_row, rows;
  logic [5:0]     cols;
  action_t        act;
  logic [7:0]     in_ch, in_at;
  logic [4:0]     in_row;

  logic [7:0]     stage_chars [MAX_COLS];
  logic [7:0]     stage_attrs [MAX_COLS];
  logic [7:0]     char_pool [POOL_BYTES];
  logic [7:0]     attr_pool [POOL_BYTES];
  logic [DW-1:0]  desc_mem [MAX_LINES];

  logic [EW-1:0]  stage_count;
  logic [LW-1:0]  oldest;
  logic [CW-1:0]  retained;
  logic [HW-1:0]  head;
  logic [LW-1:0]  view_top;
  logic           moved;
  logic [EW-1:0]  n, i, j, p_len;
  logic           live, p_hit;
  logic [HW-1:0]  p_off;
  logic [9:0]     base;
  logic [7:0]     last_attr;
  logic [7:0]     st_ch, st_at, pl_ch, pl_at;
  logic [DW-1:0]  desc_q;

  logic [4:0]     eff_rows;
  logic [EW-1:0]  eff_cols, n_c;
  logic [NW-1:0]  rows_n, ret_n, vt_n, lt_n, below_n, bl_n, step_n, want_n, line_n;
  logic           reviewing;
  logic [HW-1:0]  rd_off;
  logic [EW-1:0]  rd_len;
  logic [AW-1:0]  end_c;
  logic [LW+1:0]  slot_sum, oldest_sum;
  logic [LW-1:0]  slot_new, slot_paint, desc_addr, oldest_inc;
  logic [5:0]     fr_sum;
  logic [15:0]    prod;
  logic           cell_in;
  logic [7:0]     cell_ch, cell_at;

  always_comb begin
    eff_rows = (rows == 5'd0) ? 5'd1 : rows;
    if (cols == 6'd0) begin
      eff_cols = EW'(1);
    end else if (int'(cols) > MAX_COLS) begin
      eff_cols = EW'(MAX_COLS);
    end else begin
      eff_cols = EW'(cols);
    end
    n_c       = (stage_count > eff_cols) ? eff_cols : stage_count;
    rows_n    = NW'(eff_rows);
    ret_n     = NW'(retained);
    vt_n      = NW'(view_top);
    lt_n      = (ret_n > rows_n) ? ret_n - rows_n : '0;
    reviewing = vt_n < lt_n;
    below_n   = vt_n + rows_n;
    bl_n      = (ret_n > below_n) ? ret_n - below_n : '0;
    step_n    = (rows_n > NW'(1)) ? rows_n - NW'(1) : NW'(1);
    case (act)
      ACT_PGUP: want_n = (vt_n < step_n) ? '0 : vt_n - step_n;
      ACT_PGDN: want_n = vt_n + step_n;
      ACT_END:  want_n = lt_n;
      default:  want_n = '0;
    endcase
    if (want_n > lt_n) want_n = lt_n;
    rd_off     = desc_q[DW-1:EW];
    rd_len     = desc_q[EW-1:0];
    end_c      = AW'(head) + AW'(n);
    oldest_sum = (LW+2)'(oldest) + (LW+2)'(1);
    oldest_inc = (oldest_sum >= (LW+2)'(MAX_LINES)) ? '0 : oldest_sum[LW-1:0];
    slot_sum   = (LW+2)'(oldest) + (LW+2)'(retained);
    slot_new   = (slot_sum >= (LW+2)'(MAX_LINES)) ?
                 LW'(slot_sum - (LW+2)'(MAX_LINES)) : slot_sum[LW-1:0];
    line_n     = vt_n + NW'(in_row);
    slot_paint = ((LW+2)'(oldest) + (LW+2)'(line_n) >= (LW+2)'(MAX_LINES)) ?
                 LW'((LW+2)'(oldest) + (LW+2)'(line_n) - (LW+2)'(MAX_LINES)) :
                 LW'((LW+2)'(oldest) + (LW+2)'(line_n));
    desc_addr  = cmd.p_start ? slot_paint : oldest;
    fr_sum     = {1'b0, first_row} + {1'b0, in_row};
    prod       = 16'(fr_sum) * 16'(eff_cols);
    cell_in    = j < p_len;
    cell_ch    = cell_in ? pl_ch : BLANK;
    cell_at    = cell_in ? pl_at : PAD_ATTR;
  end

  always_comb begin
    stat.action     = act;
    stat.row_ok     = in_row < eff_rows;
    stat.have_lines = retained != '0;
    stat.ev_hit     = (AW'(head) < AW'(rd_off) + AW'(rd_len)) && (AW'(rd_off) < end_c);
    stat.cp_more    = i < n;
    stat.last_col   = (j + EW'(1)) == eff_cols;
    stat.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && act == ACT_PUT && stage_count < eff_cols) begin
      stage_chars[stage_count[SW-1:0]] <= in_ch;
      stage_attrs[stage_count[SW-1:0]] <= in_at;
    end
    if (cmd.cp_rd) begin
      st_ch <= stage_chars[i[SW-1:0]];
      st_at <= stage_attrs[i[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cp_wr) begin
      char_pool[PW'(head + HW'(i))] <= st_ch;
      attr_pool[PW'(head + HW'(i))] <= st_at;
    end
    if (cmd.p_rd) begin
      pl_ch <= char_pool[PW'(p_off + HW'(j))];
      pl_at <= attr_pool[PW'(p_off + HW'(j))];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.desc_wr) begin
      desc_mem[slot_new] <= {head, n};
    end
    if (cmd.ev_rd || cmd.p_start) begin
      desc_q <= desc_mem[desc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_row   <= 5'd0;
      rows        <= 5'd24;
      cols        <= 6'd40;
      stage_count <= '0;
      oldest      <= '0;
      retained    <= '0;
      head        <= '0;
      view_top    <= '0;
      moved       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FIRST_ROW: first_row <= cfg_data[4:0];
          REG_ROWS:      rows      <= cfg_data[4:0];
          REG_COLS:      cols      <= cfg_data;
          default:       ;
        endcase
      end
      if (m_tready) m_tvalid <= 1'b0;
      if (cmd.load_in) begin
        act    <= action_t'(s_tdata[2:0]);
        in_ch  <= s_tdata[10:3];
        in_at  <= s_tdata[18:11];
        in_row <= s_tdata[23:19];
        moved  <= 1'b0;
      end
      if (cmd.exec) begin
        case (act)
          ACT_PUT: if (stage_count < eff_cols) stage_count <= stage_count + EW'(1);
          ACT_CLEAR: begin
            stage_count <= '0;
            oldest      <= '0;
            retained    <= '0;
            head        <= '0;
            view_top    <= '0;
          end
          default: begin
            moved    <= want_n != vt_n;
            view_top <= LW'(want_n);
          end
        endcase
      end
      if (cmd.wrap) begin
        n    <= n_c;
        i    <= '0;
        live <= !reviewing;
        if (AW'(head) + AW'(n_c) > AW'(POOL_BYTES)) head <= '0;
      end
      if (cmd.ev_drop) begin
        oldest   <= oldest_inc;
        retained <= retained - CW'(1);
      end
      if (cmd.full && ret_n >= NW'(MAX_LINES)) begin
        oldest   <= oldest_inc;
        retained <= CW'(MAX_LINES - 1);
      end
      if (cmd.cp_wr) i <= i + EW'(1);
      if (cmd.desc_wr) begin
        head        <= HW'(end_c);
        retained    <= retained + CW'(1);
        stage_count <= '0;
      end
      if (cmd.view_upd && live) view_top <= LW'(lt_n);
      if (cmd.p_start) begin
        p_hit     <= line_n < ret_n;
        base      <= prod[9:0];
        j         <= '0;
        last_attr <= PAD_ATTR;
      end
      if (cmd.p_desc) begin
        p_off <= p_hit ? rd_off : '0;
        p_len <= !p_hit ? '0 : (rd_len > eff_cols) ? eff_cols : rd_len;
      end
      if (cmd.stat_load) begin
        m_tvalid <= 1'b1;
        m_tlast  <= 1'b1;
        m_tdata  <= {1'b0, 8'(view_top), 9'(retained), 9'(bl_n), reviewing, moved,
                     10'd0, 1'b0, 8'd0, 8'd0};
      end
      if (cmd.p_ld) begin
        m_tvalid  <= 1'b1;
        m_tlast   <= stat.last_col;
        m_tdata   <= {1'b0, 8'(view_top), 9'(retained), 9'(bl_n), reviewing, 1'b0,
                      base + 10'(j), cell_at != last_attr, cell_at, cell_ch};
        last_attr <= cell_at;
        j         <= j + EW'(1);
      end
    end
  end

endmodule

// ===== design/scrollback_line_ring_pager_top.sv =====
// Put cell, movement, clear: execute, then status. Paint outside the region: row check, status.
// End line: wrap, evict reads and checks, full check, cell copy, descriptor, view update, status.
// Paint row: row check, descriptor, then per cell a pool read and output load; full output stalls.
// Throughput is one item at a time.
// Reset clears control state, view, stage count and line ring; registers return to 0, 24, 40.
// Pool, descriptor and stage memories hold no reset value and need no clearing pass.
module scrollback_line_ring_pager_top #(
  parameter int POOL_BYTES = slrp_pkg::POOL_BYTES_DEF,
  parameter int MAX_LINES  = slrp_pkg::MAX_LINES_DEF,
  parameter int MAX_COLS   = slrp_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [slrp_pkg::CIDX_W-1:0] cfg_index,
  input  logic [slrp_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // action, cell_char, cell_attr, view_row
  input  logic [slrp_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_char, out_attr, attr_changed, screen_address, view_moved, reviewing,
  // backlog, line_count, view_top
  output logic [slrp_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tlast
);
  import slrp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slrp_datapath #(
    .POOL_BYTES (POOL_BYTES),
    .MAX_LINES  (MAX_LINES),
    .MAX_COLS   (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  a_review_backlog: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> m_tdata[37:29] != 9'd0)
    else $error("reviewing with no backlog");

  a_view_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> {1'b0, m_tdata[54:47]} < m_tdata[46:38])
    else $error("view top beyond retained lines");

endmodule

// ===== bench/tb.sv =====
// Testbench for the scrollback line ring pager: directed and random commands vs a predictor.
`timescale 1ns / 1ps

module tb;
  import slrp_pkg::*;

  localparam int POOL = POOL_BYTES_DEF;
  localparam int SLOTS = MAX_LINES_DEF;
  localparam int COLS_MAX = MAX_COLS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [7:0] view_top;
    logic [8:0] line_count;
    logic [8:0] backlog;
    logic       reviewing;
    logic       view_moved;
    logic [9:0] screen_address;
    logic       attr_changed;
    logic [7:0] out_attr;
    logic [7:0] out_char;
  } cell_result_t;

  typedef struct {
    cell_result_t r;
    logic         last;
  } painted_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;

  scrollback_line_ring_pager_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  // predictor state
  int unsigned first_row_reg, rows_reg, cols_reg;
  logic [7:0] char_mem [POOL];
  logic [7:0] attr_mem [POOL];
  int unsigned line_base [SLOTS];
  int unsigned line_size [SLOTS];
  int unsigned head_slot, line_total, pool_head, top_line, staged;
  logic [7:0] staged_char [COLS_MAX];
  logic [7:0] staged_attr [COLS_MAX];

  painted_t pending_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int mismatches = 0;
  int unsigned cycles = 0;

  function automatic int unsigned rows_eff();
    return rows_reg == 0 ? 1 : rows_reg;
  endfunction

  function automatic int unsigned cols_eff();
    if (cols_reg == 0) return 1;
    return cols_reg > COLS_MAX ? COLS_MAX : cols_reg;
  endfunction

  function automatic int unsigned newest_top();
    return line_total > rows_eff() ? line_total - rows_eff() : 0;
  endfunction

  function automatic void push_result(int unsigned ch, int unsigned at, bit chg,
                                      int unsigned addr, bit last, bit moved);
    painted_t p;
    int unsigned below;
    below = top_line + rows_eff();
    p.r.out_char = ch[7:0];
    p.r.out_attr = at[7:0];
    p.r.attr_changed = chg;
    p.r.screen_address = addr[9:0];
    p.r.view_moved = moved;
    p.r.reviewing = top_line < newest_top();
    p.r.backlog = line_total > below ? 9'(line_total - below) : 9'd0;
    p.r.line_count = line_total[8:0];
    p.r.view_top = top_line[7:0];
    p.last = last;
    pending_q.push_back(p);
  endfunction

  function automatic bit scroll_to(int unsigned want);
    if (want > newest_top()) want = newest_top();
    if (want == top_line) return 1'b0;
    top_line = want;
    return 1'b1;
  endfunction

  function automatic void store_line();
    int unsigned n, stop, slot;
    bit follow;
    follow = !(top_line < newest_top());
    n = staged > cols_eff() ? cols_eff() : staged;
    if (pool_head + n > POOL) pool_head = 0;
    stop = pool_head + n;
    while (line_total > 0) begin
      if (pool_head < line_base[head_slot] + line_size[head_slot] &&
          line_base[head_slot] < stop) begin
        head_slot = (head_slot + 1) % SLOTS;
        line_total--;
      end else break;
    end
    if (line_total >= SLOTS) begin
      head_slot = (head_slot + 1) % SLOTS;
      line_total = SLOTS - 1;
    end
    for (int i = 0; i < n; i++) begin
      char_mem[pool_head + i] = staged_char[i];
      attr_mem[pool_head + i] = staged_attr[i];
    end
    slot = (head_slot + line_total) % SLOTS;
    line_base[slot] = pool_head;
    line_size[slot] = n;
    pool_head = stop;
    line_total++;
    staged = 0;
    if (follow) top_line = newest_top();
  endfunction

  function automatic void emit_row(int unsigned row);
    int unsigned cols, line, off, len, base, ch, at, prev;
    cols = cols_eff();
    line = top_line + row;
    off = 0;
    len = 0;
    prev = PAD_ATTR;
    base = (first_row_reg + row) * cols;
    if (line < line_total) begin
      off = line_base[(head_slot + line) % SLOTS];
      len = line_size[(head_slot + line) % SLOTS];
      if (len > cols) len = cols;
    end
    for (int j = 0; j < cols; j++) begin
      ch = BLANK;
      at = PAD_ATTR;
      if (j < len) begin
        ch = char_mem[off + j];
        at = attr_mem[off + j];
      end
      push_result(ch, at, at != prev, base + j, j + 1 == cols, 1'b0);
      prev = at;
    end
  endfunction

  function automatic void predict_command(action_t act, logic [7:0] ch, logic [7:0] at,
                                          logic [4:0] row);
    int unsigned step;
    bit moved;
    step = rows_eff() > 1 ? rows_eff() - 1 : 1;
    moved = 1'b0;
    case (act)
      ACT_PUT: begin
        if (staged < cols_eff()) begin
          staged_char[staged] = ch;
          staged_attr[staged] = at;
          staged++;
        end
      end
      ACT_EOL: store_line();
      ACT_PGUP: moved = scroll_to(top_line < step ? 0 : top_line - step);
      ACT_PGDN: moved = scroll_to(top_line + step);
      ACT_HOME: moved = scroll_to(0);
      ACT_END: moved = scroll_to(newest_top());
      ACT_PAINT: begin
        if (row < rows_eff()) begin
          emit_row(row);
          return;
        end
      end
      default: begin
        head_slot = 0;
        line_total = 0;
        pool_head = 0;
        top_line = 0;
        staged = 0;
      end
    endcase
    push_result(0, 0, 1'b0, 0, 1'b1, moved);
  endfunction

  task automatic send_command(action_t act, logic [7:0] ch = 8'h00, logic [7:0] at = 8'h00,
                              logic [4:0] row = 5'd0);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row, at, ch, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(act, ch, at, row);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FIRST_ROW: first_row_reg = value & 5'h1f;
      REG_ROWS: rows_reg = value & 5'h1f;
      default: cols_reg = value & 6'h3f;
    endcase
  endtask

  task automatic set_region(int unsigned first, int unsigned rows, int unsigned cols);
    write_reg(REG_FIRST_ROW, first);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  task automatic send_line(int unsigned len);
    for (int i = 0; i < len; i++)
      send_command(ACT_PUT, 8'($urandom), 8'($urandom));
    send_command(ACT_EOL);
  endtask

  task automatic test_status_on_empty();
    for (int a = 0; a < 8; a++)
      send_command(action_t'(a), 8'hff, 8'hff, 5'd0);
  endtask

  task automatic test_directed();
    set_region(2, 3, 4);
    send_command(ACT_PUT, 8'h00, 8'h00);
    send_command(ACT_PUT, 8'hff, 8'hff);
    send_command(ACT_PUT, 8'h55, PAD_ATTR);
    send_command(ACT_PUT, 8'haa, 8'haa);
    send_command(ACT_PUT, 8'h11, 8'h22);
    send_command(ACT_EOL);
    send_command(ACT_EOL);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd0);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd2);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd31);
    send_line(2);
    send_line(4);
    send_command(ACT_PGUP);
    send_command(ACT_PGUP);
    send_command(ACT_PGDN);
    send_command(ACT_END);
    send_command(ACT_HOME);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd1);
    send_command(ACT_CLEAR);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd0);
  endtask

  task automatic test_register_extremes();
    set_region(31, 0, 0);
    send_line(3);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd0);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd1);
    send_command(ACT_PGUP);
    set_region(24, 31, 63);
    send_line(41);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd30);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd0);
    set_region(0, 25, 1);
    send_command(ACT_PAINT, 8'h00, 8'h00, 5'd0);
    send_command(ACT_CLEAR);
  endtask

  task automatic random_commands(int unsigned count);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) send_command(ACT_PUT, 8'($urandom), 8'($urandom));
      else if (pick < 62) send_command(ACT_EOL);
      else if (pick < 68) send_command(ACT_PGUP);
      else if (pick < 74) send_command(ACT_PGDN);
      else if (pick < 78) send_command(ACT_HOME);
      else if (pick < 82) send_command(ACT_END);
      else if (pick < 97) send_command(ACT_PAINT, 8'($urandom), 8'($urandom),
                                       $urandom_range(3) == 0 ? 5'($urandom)
                                                              : 5'($urandom_range(rows_eff()-1)));
      else send_command(ACT_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom));
    end
  endtask

  task automatic test_random_phases();
    set_region(0, 24, 40);
    random_commands(36);
    set_region($urandom_range(24), $urandom_range(25, 1), $urandom_range(40, 1));
    send_idle_pct = 79;
    random_commands(36);
    set_region($urandom_range(24), 4, 8);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    random_commands(36);
    set_region($urandom_range(31), $urandom_range(31), $urandom_range(63));
    send_idle_pct = 30;
    recv_stall_pct = 30;
    random_commands(37);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cell_result_t got;
    painted_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(cell_result_t)-1:0];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h last %b", got, m_tlast);
      end else begin
        want = pending_q.pop_front();
        if (got !== want.r || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp ch %h at %h chg %b addr %0d last %b mv %b rv %b bl %0d",
                      " lc %0d vt %0d | got ch %h at %h chg %b addr %0d last %b mv %b rv %b",
                      " bl %0d lc %0d vt %0d"},
                     want.r.out_char, want.r.out_attr, want.r.attr_changed,
                     want.r.screen_address, want.last, want.r.view_moved, want.r.reviewing,
                     want.r.backlog, want.r.line_count, want.r.view_top,
                     got.out_char, got.out_attr, got.attr_changed, got.screen_address,
                     m_tlast, got.view_moved, got.reviewing, got.backlog, got.line_count,
                     got.view_top);
        end
      end
    end
  end

  initial begin
    first_row_reg = 0;
    rows_reg = 24;
    cols_reg = 40;
    head_slot = 0;
    line_total = 0;
    pool_head = 0;
    top_line = 0;
    staged = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_status_on_empty();
    test_directed();
    test_register_extremes();
    test_random_phases();
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
